/* rtl/line_edit_buffer_core_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef LINE_EDIT_BUFFER_CORE_MACROS_SVH
`define LINE_EDIT_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LEB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LEB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/leb_pkg.sv */
`timescale 1ns / 1ps

package leb_pkg;

    localparam int LEB_DEPTH  = 4096;
    localparam int LEB_ADDR_W = 12;
    localparam int LEB_POS_W  = 13;
    localparam int LEB_CP_W   = 21;
    localparam int LEB_WID_W  = 2;

    typedef enum logic [3:0] {
        OP_INSERT    = 4'd0,
        OP_PUSH      = 4'd1,
        OP_LEFT      = 4'd2,
        OP_RIGHT     = 4'd3,
        OP_FIRST     = 4'd4,
        OP_LAST      = 4'd5,
        OP_DELETE    = 4'd6,
        OP_BACKSPACE = 4'd7,
        OP_KILLSTART = 4'd8,
        OP_KILLEND   = 4'd9,
        OP_CLEAR     = 4'd10,
        OP_READ      = 4'd11
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                   op;
        logic [LEB_CP_W-1:0]   code_point;
        logic [LEB_WID_W-1:0]  char_width;
        logic [LEB_ADDR_W-1:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic                  status;
        logic [LEB_WID_W-1:0]  width_out;
        logic [LEB_CP_W-1:0]   char_out;
        logic [LEB_POS_W-1:0]  cursor_pos;
        logic [LEB_POS_W-1:0]  line_length;
    } t_out_item;

    typedef struct packed {
        logic [LEB_WID_W-1:0] width;
        logic [LEB_CP_W-1:0]  cp;
    } t_entry;

    typedef struct packed {
        logic                  we;
        logic [LEB_ADDR_W-1:0] waddr;
        t_entry                wdata;
        logic                  re;
        logic [LEB_ADDR_W-1:0] raddr;
    } t_mem_req;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

endpackage

/* rtl/line_edit_buffer_core.sv */
// Line edit buffer: one line of up to 4096 code points, each kept with its
// 2-bit display width, plus a cursor and a length. Each input transfer is one
// command and yields exactly one result transfer (status, width, character,
// cursor, length). Commands are taken one at a time. Cursor moves, first,
// last, kill to end, clear, read and every refused command go straight to
// the done state. Commands that move the tail run through the
// single-port-per-direction line memory one entry per cycle: insert and
// push move (length - cursor) entries, delete (length - cursor - 1),
// backspace and kill to start (length - cursor). A finished result waits in
// the output register while the next command is already taken and worked
// on. Line entries need no clearing after reset: only entries below the
// length are ever read, and those have been written.
`timescale 1ns / 1ps
`include "line_edit_buffer_core_macros.svh"

module line_edit_buffer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  leb_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output leb_pkg::t_out_item o_out_data
);
    import leb_pkg::*;

    // Control state
    t_state r_state, n_state;
    logic [LEB_POS_W-1:0] r_cursor, n_cursor;
    logic [LEB_POS_W-1:0] r_length, n_length;
    logic                 r_out_valid;

    // Tail move engine: source, destination, remaining count, direction
    logic [LEB_ADDR_W-1:0] r_src, n_src;
    logic [LEB_ADDR_W-1:0] r_dst, n_dst;
    logic [LEB_ADDR_W-1:0] r_cnt, n_cnt;
    logic                  r_up, n_up;
    // Write stage of the move: data read last cycle lands at r_wdst
    logic                  r_wr_v, n_wr_v;
    logic [LEB_ADDR_W-1:0] r_wdst, n_wdst;

    // Pending insert write, done once the tail has moved
    logic                  r_ins, n_ins;
    logic [LEB_ADDR_W-1:0] r_ins_addr, n_ins_addr;
    t_entry                r_ins_data, n_ins_data;

    // Result fields built at command start; r_wsel/r_csel take them from memory
    logic                  r_status, n_status;
    logic [LEB_WID_W-1:0]  r_width, n_width;
    logic                  r_wsel, n_wsel;
    logic                  r_csel, n_csel;

    logic      out_load;
    t_out_item r_out_data;
    t_mem_req  mem_req;
    t_entry    mem_rdata;

    logic [LEB_POS_W-1:0] w_tail;
    logic [LEB_POS_W-1:0] w_tail_m1;
    logic [LEB_POS_W-1:0] w_cur_m1;
    logic [LEB_POS_W-1:0] w_cur_p1;
    logic [LEB_POS_W-1:0] w_len_m1;

    assign w_tail    = r_length - r_cursor;
    assign w_tail_m1 = w_tail - LEB_POS_W'(1);
    assign w_cur_m1  = r_cursor - LEB_POS_W'(1);
    assign w_cur_p1  = r_cursor + LEB_POS_W'(1);
    assign w_len_m1  = r_length - LEB_POS_W'(1);

    leb_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_length    <= '0;
            r_wr_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_length <= n_length;
            r_wr_v   <= n_wr_v;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_cnt      <= n_cnt;
        r_up       <= n_up;
        r_wdst     <= n_wdst;
        r_ins      <= n_ins;
        r_ins_addr <= n_ins_addr;
        r_ins_data <= n_ins_data;
        r_status   <= n_status;
        r_width    <= n_width;
        r_wsel     <= n_wsel;
        r_csel     <= n_csel;
        if (out_load) begin
            r_out_data.status      <= r_status;
            r_out_data.width_out   <= r_wsel ? mem_rdata.width : r_width;
            r_out_data.char_out    <= r_csel ? mem_rdata.cp : '0;
            r_out_data.cursor_pos  <= r_cursor;
            r_out_data.line_length <= r_length;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_length   = r_length;
        n_src      = r_src;
        n_dst      = r_dst;
        n_cnt      = r_cnt;
        n_up       = r_up;
        n_wr_v     = 1'b0;
        n_wdst     = r_wdst;
        n_ins      = r_ins;
        n_ins_addr = r_ins_addr;
        n_ins_data = r_ins_data;
        n_status   = r_status;
        n_width    = r_width;
        n_wsel     = r_wsel;
        n_csel     = r_csel;
        out_load   = 1'b0;

        // Move write stage owns the write port whenever it holds data
        mem_req.we    = r_wr_v;
        mem_req.waddr = r_wdst;
        mem_req.wdata = mem_rdata;
        mem_req.re    = 1'b0;
        mem_req.raddr = r_src;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Default: refused, nothing moves, go to done
                    n_state  = S_DONE;
                    n_status = STATUS_REFUSED;
                    n_width  = '0;
                    n_wsel   = 1'b0;
                    n_csel   = 1'b0;
                    n_ins    = 1'b0;
                    n_cnt    = '0;
                    unique case (i_in_data.op) inside
                        OP_INSERT, OP_PUSH: begin
                            if (r_length < LEB_POS_W'(LEB_DEPTH)) begin
                                // Shift the tail right from the end down to the cursor
                                n_status         = STATUS_DONE;
                                n_width          = i_in_data.char_width;
                                n_src            = w_len_m1[LEB_ADDR_W-1:0];
                                n_dst            = r_length[LEB_ADDR_W-1:0];
                                n_cnt            = w_tail[LEB_ADDR_W-1:0];
                                n_up             = 1'b0;
                                n_ins            = 1'b1;
                                n_ins_addr       = r_cursor[LEB_ADDR_W-1:0];
                                n_ins_data.width = i_in_data.char_width;
                                n_ins_data.cp    = i_in_data.code_point;
                                n_length         = r_length + LEB_POS_W'(1);
                                if (i_in_data.op == OP_PUSH) begin
                                    n_cursor = w_cur_p1;
                                end
                                n_state          = S_SHIFT;
                            end
                        end
                        OP_LEFT: begin
                            if (r_cursor != '0) begin
                                n_status      = STATUS_DONE;
                                n_wsel        = 1'b1;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = w_cur_m1[LEB_ADDR_W-1:0];
                                n_cursor      = w_cur_m1;
                            end
                        end
                        OP_RIGHT: begin
                            if (r_cursor < r_length) begin
                                n_status      = STATUS_DONE;
                                n_wsel        = 1'b1;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = r_cursor[LEB_ADDR_W-1:0];
                                n_cursor      = w_cur_p1;
                            end
                        end
                        OP_FIRST: begin
                            n_status = STATUS_DONE;
                            n_cursor = '0;
                        end
                        OP_LAST: begin
                            n_status = STATUS_DONE;
                            n_cursor = r_length;
                        end
                        OP_DELETE: begin
                            if (r_cursor < r_length) begin
                                // Pull the tail left over the entry under the cursor
                                n_status = STATUS_DONE;
                                n_src    = w_cur_p1[LEB_ADDR_W-1:0];
                                n_dst    = r_cursor[LEB_ADDR_W-1:0];
                                n_cnt    = w_tail_m1[LEB_ADDR_W-1:0];
                                n_up     = 1'b1;
                                n_length = w_len_m1;
                                n_state  = S_SHIFT;
                            end
                        end
                        OP_BACKSPACE: begin
                            if (r_cursor != '0) begin
                                n_status = STATUS_DONE;
                                n_src    = r_cursor[LEB_ADDR_W-1:0];
                                n_dst    = w_cur_m1[LEB_ADDR_W-1:0];
                                n_cnt    = w_tail[LEB_ADDR_W-1:0];
                                n_up     = 1'b1;
                                n_length = w_len_m1;
                                n_cursor = w_cur_m1;
                                n_state  = S_SHIFT;
                            end
                        end
                        OP_KILLSTART: begin
                            if (r_cursor != '0) begin
                                // Move the tail to the front; cursor at end empties the line
                                n_status = STATUS_DONE;
                                n_src    = r_cursor[LEB_ADDR_W-1:0];
                                n_dst    = '0;
                                n_cnt    = w_tail[LEB_ADDR_W-1:0];
                                n_up     = 1'b1;
                                n_length = w_tail;
                                n_cursor = '0;
                                n_state  = S_SHIFT;
                            end
                        end
                        OP_KILLEND: begin
                            if (r_cursor < r_length) begin
                                n_status = STATUS_DONE;
                                n_length = r_cursor;
                            end
                        end
                        OP_CLEAR: begin
                            n_status = STATUS_DONE;
                            n_cursor = '0;
                            n_length = '0;
                        end
                        OP_READ: begin
                            if ({1'b0, i_in_data.read_index} < r_length) begin
                                n_status      = STATUS_DONE;
                                n_wsel        = 1'b1;
                                n_csel        = 1'b1;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = i_in_data.read_index;
                            end
                        end
                        default: begin
                            // Undefined op codes: refuse
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_cnt != '0) begin
                    // Read one entry, write it at its destination next cycle
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_src;
                    n_wr_v        = 1'b1;
                    n_wdst        = r_dst;
                    n_src         = r_up ? r_src + LEB_ADDR_W'(1) : r_src - LEB_ADDR_W'(1);
                    n_dst         = r_up ? r_dst + LEB_ADDR_W'(1) : r_dst - LEB_ADDR_W'(1);
                    n_cnt         = r_cnt - LEB_ADDR_W'(1);
                end else if (!r_wr_v) begin
                    // Tail in place: drop the new entry at the cursor
                    if (r_ins) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = r_ins_addr;
                        mem_req.wdata = r_ins_data;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free, then load it
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `LEB_ASSERT_IMPL(a_cursor_in_line, i_clk, i_rst_n, 1'b1, r_cursor <= r_length,
                     "cursor past length")
    `LEB_ASSERT_IMPL(a_length_in_range, i_clk, i_rst_n, 1'b1,
                     r_length <= LEB_POS_W'(LEB_DEPTH), "length past depth")
    `LEB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready,
                     !o_in_ready, "ready right after transfer")
    `LEB_ASSERT_IMPL(a_move_write_in_shift, i_clk, i_rst_n, r_wr_v, r_state == S_SHIFT,
                     "move write outside shift")

endmodule

/* rtl/leb_store.sv */
`timescale 1ns / 1ps

module leb_store (
    input  logic             i_clk,
    input  leb_pkg::t_mem_req i_req,
    output leb_pkg::t_entry  o_rdata
);
    import leb_pkg::*;

    t_entry r_mem [LEB_DEPTH];
    t_entry r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
